/* src/ftma_pkg.sv */
// Shared constants, types and register codes for the frame-time moving average unit.
// No dependencies; every other file of the block imports this package.
package ftma_pkg;

  // Window depth and fixed-point format
  localparam int WINDOW        = 256;
  localparam int FRACTION_BITS = 16;

  // Field widths
  localparam int TS_W    = 64;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = $clog2(WINDOW + 1);
  localparam int HEAD_W  = $clog2(WINDOW);
  localparam int SUM_W   = TIME_W + $clog2(WINDOW);

  // Tick-to-millisecond scale factor, 1000 * 2^FRACTION_BITS
  localparam longint unsigned SCALE_VALUE = 64'd1000 << FRACTION_BITS;
  localparam int SCALE_W = $clog2(SCALE_VALUE + 1);
  localparam int PART_W  = TIME_W + SCALE_W;
  localparam int PROD_W  = TS_W + SCALE_W;

  // Shared divider sizing
  localparam int DIV_W  = (SUM_W > TIME_W) ? SUM_W : TIME_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COUNTER_FREQUENCY = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DELTA_TIME    = 1'd1;

  localparam logic [TIME_W-1:0] FREQ_RESET      = 32'd10000000;
  localparam logic [TIME_W-1:0] MAX_DELTA_RESET = 32'd6553600;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] rem_init;
    logic [DIV_W-1:0]  dividend;
    logic [TIME_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* src/ftma_if.sv */
// Valid/ready channel interfaces for timestamp beats in and result beats out.
// Depends on ftma_pkg for field widths.
interface ftma_sample_if import ftma_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] timestamp;

  modport source (output valid, output timestamp, input ready);
  modport sink   (input valid, input timestamp, output ready);
endinterface

interface ftma_result_if import ftma_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  frame_time;
  logic [TIME_W-1:0]  clamped_delta;
  logic [TIME_W-1:0]  average_frame_time;
  logic [COUNT_W-1:0] samples_in_window;

  modport source (output valid, output frame_time, output clamped_delta,
                  output average_frame_time, output samples_in_window, input ready);
  modport sink   (input valid, input frame_time, input clamped_delta,
                  input average_frame_time, input samples_in_window, output ready);
endinterface

/* src/ftma_ring.sv */
// History ring of frame times: one write port, one read port, registered read data.
// Depends on ftma_pkg for depth and width.
module ftma_ring import ftma_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [HEAD_W-1:0] wr_addr,
  input  logic [TIME_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [HEAD_W-1:0] rd_addr,
  output logic [TIME_W-1:0] rd_data
);

  logic [TIME_W-1:0] mem [WINDOW];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/ftma_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on ftma_pkg for div_req_t / div_rsp_t.
module ftma_div import ftma_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [TIME_W-1:0] rem;
  logic [DIV_W-1:0]  acc;
  logic [TIME_W-1:0] dvs;
  logic [STEP_W-1:0] cnt;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;
  logic              fits;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {rem, acc[DIV_W-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  // Control: load on start, count steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      acc <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      acc <= {acc[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = acc;

endmodule

/* src/frame_time_moving_average_unit.sv */
// Frame-time moving average: one timestamp beat in, one result beat out.
// Each beat passes a low-half and a high-half multiply step, a frame-time division
// (skipped when it saturates), the window update and an average division, both on
// the one shared bit-serial divider. One beat is worked on at a time; the next is taken
// while a finished result waits in the output register. Reset is synchronous and
// immediate: the ring is not swept, entries beyond the fill count read as zero.
module frame_time_moving_average_unit import ftma_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  ftma_sample_if.sink            sample,
  ftma_result_if.source          result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_LO, S_MUL_HI, S_CHECK, S_FT_DIV, S_UPDATE, S_AVG_DIV, S_HOLD
  } state_t;

  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(SCALE_VALUE);

  state_t             state;
  logic [TIME_W-1:0]  counter_frequency;
  logic [TIME_W-1:0]  max_delta_time;
  logic [TS_W-1:0]    previous_timestamp;
  logic [TS_W-1:0]    delta;
  logic [PROD_W-1:0]  prod;
  logic [TIME_W-1:0]  ft;
  logic [TIME_W-1:0]  old;
  logic [TIME_W-1:0]  avg;
  logic [SUM_W-1:0]   window_sum;
  logic [HEAD_W-1:0]  ring_head;
  logic [COUNT_W-1:0] sample_count;
  logic               res_valid;

  logic [TIME_W-1:0]  half;
  logic [PART_W-1:0]  part;
  logic               saturate;
  logic               full;
  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0] count_next;
  logic [HEAD_W-1:0]  head_next;
  logic               accept;
  logic               out_free;
  logic [TIME_W-1:0]  ring_rdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign accept   = sample.valid && sample.ready;
  assign out_free = !res_valid || result.ready;
  assign full     = sample_count == COUNT_W'(WINDOW);

  // Partial product of one delta half with the scale factor
  always_comb begin
    half = (state == S_MUL_LO) ? delta[TIME_W-1:0] : delta[TS_W-1:TIME_W];
    part = PART_W'(half) * PART_W'(SCALE);
  end

  // Saturate on zero frequency or a quotient that needs more than 32 bits
  assign saturate = (counter_frequency == '0) ||
                    (prod[PROD_W-1:TIME_W] >= (PROD_W-TIME_W)'(counter_frequency));

  // Window bookkeeping for the update step
  always_comb begin
    sum_next   = window_sum - SUM_W'(old) + SUM_W'(ft);
    count_next = full ? sample_count : sample_count + COUNT_W'(1);
    head_next  = (ring_head == HEAD_W'(WINDOW - 1)) ? '0 : ring_head + HEAD_W'(1);
  end

  // Divider requests: frame time from the check step, average from the update step
  always_comb begin
    div_req = '0;
    if (state == S_CHECK) begin
      div_req.start    = !saturate;
      div_req.rem_init = prod[2*TIME_W-1:TIME_W];
      div_req.dividend = DIV_W'(prod[TIME_W-1:0]) << (DIV_W - TIME_W);
      div_req.divisor  = counter_frequency;
      div_req.steps    = STEP_W'(TIME_W);
    end else if (state == S_UPDATE) begin
      div_req.start    = 1'b1;
      div_req.rem_init = '0;
      div_req.dividend = DIV_W'(sum_next);
      div_req.divisor  = TIME_W'(count_next);
      div_req.steps    = STEP_W'(DIV_W);
    end
  end

  ftma_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ftma_ring u_ring (
    .clk     (clk),
    .wr_en   (state == S_UPDATE),
    .wr_addr (ring_head),
    .wr_data (ft),
    .rd_en   (accept),
    .rd_addr (ring_head),
    .rd_data (ring_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_frequency <= FREQ_RESET;
      max_delta_time    <= MAX_DELTA_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COUNTER_FREQUENCY: counter_frequency <= cfg_data;
        CFG_MAX_DELTA_TIME:    max_delta_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: state, window state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      previous_timestamp <= '0;
      window_sum         <= '0;
      ring_head          <= '0;
      sample_count       <= '0;
      res_valid          <= 1'b0;
    end else begin
      // Raise the flag when a new beat loads, drop it once the beat is taken
      if (state == S_HOLD && out_free) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            delta              <= sample.timestamp - previous_timestamp;
            previous_timestamp <= sample.timestamp;
            state              <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          prod  <= PROD_W'(part);
          old   <= full ? ring_rdata : '0;
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod  <= prod + (PROD_W'(part) << TIME_W);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (saturate) begin
            ft    <= '1;
            state <= S_UPDATE;
          end else begin
            state <= S_FT_DIV;
          end
        end
        S_FT_DIV: begin
          if (div_rsp.done) begin
            ft    <= div_rsp.quotient[TIME_W-1:0];
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          window_sum   <= sum_next;
          sample_count <= count_next;
          ring_head    <= head_next;
          state        <= S_AVG_DIV;
        end
        S_AVG_DIV: begin
          if (div_rsp.done) begin
            avg   <= div_rsp.quotient[TIME_W-1:0];
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            result.frame_time         <= ft;
            result.clamped_delta      <= (ft < max_delta_time) ? ft : max_delta_time;
            result.average_frame_time <= avg;
            result.samples_in_window  <= sample_count;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample.ready = (state == S_IDLE);
  assign result.valid = res_valid;

endmodule

/* src/ftma_checker.sv */
// Port-level assertions for the frame-time moving average unit, bound to the top level.
// Depends on ftma_pkg and frame_time_moving_average_unit.
module ftma_checker import ftma_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [TIME_W-1:0]  frame_time,
  input logic [TIME_W-1:0]  clamped_delta,
  input logic [TIME_W-1:0]  average_frame_time,
  input logic [COUNT_W-1:0] samples_in_window
);

  // Reset drops any pending result beat
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(frame_time) &&
    $stable(average_frame_time) && $stable(samples_in_window))
    else $error("stalled result beat changed");

  // Clamp never raises the frame time
  a_clamp_le: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> clamped_delta <= frame_time)
    else $error("clamped delta above frame time");

  // Sample count stays within the window
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> samples_in_window != '0 && samples_in_window <= COUNT_W'(WINDOW))
    else $error("sample count out of range");

  // A single-sample window averages to that sample
  a_first_avg: assert property (@(posedge clk) disable iff (rst)
    res_valid && samples_in_window == COUNT_W'(1) |-> average_frame_time == frame_time)
    else $error("single-sample average mismatch");

endmodule

bind frame_time_moving_average_unit ftma_checker u_ftma_checker (
  .clk                (clk),
  .rst                (rst),
  .res_valid          (result.valid),
  .res_ready          (result.ready),
  .frame_time         (result.frame_time),
  .clamped_delta      (result.clamped_delta),
  .average_frame_time (result.average_frame_time),
  .samples_in_window  (result.samples_in_window)
);

/* tb/frame_time_moving_average_unit_test.sv */
// Testbench for frame_time_moving_average_unit: drives timestamp beats with random gaps,
// predicts frame time, clamp and window average per beat and checks every result beat.
// Depends on ftma_pkg, ftma_if and the unit itself.
`timescale 1ns / 100ps

module frame_time_moving_average_unit_test;
  import ftma_pkg::*;

  typedef struct {
    logic [TIME_W-1:0]  frame_time;
    logic [TIME_W-1:0]  clamped_delta;
    logic [TIME_W-1:0]  average_frame_time;
    logic [COUNT_W-1:0] samples_in_window;
  } frame_stats_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [TIME_W-1:0]      cfg_data;

  ftma_sample_if sample_ch ();
  ftma_result_if result_ch ();

  frame_time_moving_average_unit uut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus and expectation stores
  logic [TS_W-1:0] timestamps_to_send[$];
  frame_stats_t    frame_stats_due[$];
  logic [TS_W-1:0] last_queued_ts;
  bit              idle_on;
  int              mismatch_count;
  int              results_seen;
  int              send_gap;
  int              hold_cycles;

  // Shadow of the unit's registers and window state
  logic [TIME_W-1:0]  freq_setting;
  logic [TIME_W-1:0]  limit_setting;
  logic [TS_W-1:0]    prev_ts;
  logic [TIME_W-1:0]  history[WINDOW];
  logic [HEAD_W-1:0]  head;
  logic [SUM_W-1:0]   window_total;
  logic [COUNT_W-1:0] fill_count;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_COUNTER_FREQUENCY;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.timestamp = '0;
    result_ch.ready = 1'b0;
  end

  always #2 clk = ~clk;

  // Scale a tick delta to Q16.16 milliseconds, saturating at the 32-bit maximum
  function automatic logic [TIME_W-1:0] frame_time_of(logic [TS_W-1:0] delta,
                                                      logic [TIME_W-1:0] freq);
    logic [127:0] scaled;
    logic [127:0] quot;
    if (freq == '0) return '1;
    scaled = 128'(delta) * (128'd1000 << FRACTION_BITS);
    quot = scaled / 128'(freq);
    if (quot > 128'hFFFF_FFFF) return '1;
    return quot[TIME_W-1:0];
  endfunction

  // Advance the window by one frame and queue the result it must produce
  task automatic predict_frame_stats(input logic [TS_W-1:0] ts);
    frame_stats_t      stats;
    logic [TIME_W-1:0] ft;
    ft = frame_time_of(ts - prev_ts, freq_setting);
    window_total = window_total - SUM_W'(history[head]) + SUM_W'(ft);
    history[head] = ft;
    head = head + 1'b1;
    if (fill_count < COUNT_W'(WINDOW)) fill_count = fill_count + 1'b1;
    prev_ts = ts;
    stats.frame_time = ft;
    stats.clamped_delta = (ft < limit_setting) ? ft : limit_setting;
    stats.average_frame_time = TIME_W'(window_total / SUM_W'(fill_count));
    stats.samples_in_window = fill_count;
    frame_stats_due.push_back(stats);
  endtask

  task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 200);
    return $urandom_range(1, 3);
  endfunction

  // Next timestamp: mostly plausible frame deltas, some odd and broken ones
  function automatic logic [TS_W-1:0] random_timestamp(logic [TS_W-1:0] prev,
                                                       logic [TIME_W-1:0] freq);
    int unsigned pick;
    logic [TS_W-1:0] ticks;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      ticks = 64'(freq) * 64'($urandom_range(1, 100)) / 64'd1000;
      return prev + ticks + 64'($urandom_range(0, 1023));
    end
    if (pick < 72) return prev + 64'($urandom_range(0, 4096));
    if (pick < 84) return prev + ((64'($urandom) << $urandom_range(0, 12)) >>
                                  $urandom_range(0, 31));
    if (pick < 92) return {$urandom, $urandom};
    if (pick < 96) return '1 - 64'($urandom_range(0, 4095));
    return prev - 64'($urandom_range(1, 1000));
  endfunction

  task automatic queue_timestamp(input logic [TS_W-1:0] ts);
    timestamps_to_send.push_back(ts);
    last_queued_ts = ts;
  endtask

  task automatic queue_delta(input logic [TS_W-1:0] delta);
    queue_timestamp(last_queued_ts + delta);
  endtask

  // Hold until every queued beat is sent and every result has come back
  task automatic wait_drained();
    while (timestamps_to_send.size() != 0 || sample_ch.valid || frame_stats_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic program_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [TIME_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_COUNTER_FREQUENCY) freq_setting = value;
    else limit_setting = value;
  endtask

  task automatic reconfigure(input logic [TIME_W-1:0] freq, input logic [TIME_W-1:0] limit);
    wait_drained();
    program_register(CFG_COUNTER_FREQUENCY, freq);
    program_register(CFG_MAX_DELTA_TIME, limit);
  endtask

  // Driver: offer timestamp beats, predict on each accepted one
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) predict_frame_stats(sample_ch.timestamp);
      if (!sample_ch.valid || sample_ch.ready) begin
        if (send_gap != 0) begin
          sample_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (timestamps_to_send.size() != 0) begin
          if (idle_on && $urandom_range(0, 5) == 0) begin
            sample_ch.valid <= 1'b0;
            send_gap <= pick_gap() - 1;
          end else begin
            sample_ch.valid <= 1'b1;
            sample_ch.timestamp <= timestamps_to_send.pop_front();
          end
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat, stall the output now and then
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_cycles <= 0;
      results_seen <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen <= results_seen + 1;
        if (frame_stats_due.size() == 0) begin
          $error("unexpected result beat: frame_time %0d", result_ch.frame_time);
          mismatch_count++;
        end else begin
          frame_stats_t want;
          want = frame_stats_due.pop_front();
          compare_field("frame_time", want.frame_time, result_ch.frame_time);
          compare_field("clamped_delta", want.clamped_delta, result_ch.clamped_delta);
          compare_field("average_frame_time", want.average_frame_time,
                        result_ch.average_frame_time);
          compare_field("samples_in_window", TIME_W'(want.samples_in_window),
                        TIME_W'(result_ch.samples_in_window));
        end
      end
      if (hold_cycles != 0) begin
        result_ch.ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else if (result_ch.valid && result_ch.ready && results_seen % 700 == 349) begin
        // long back-pressure so the unit fills up and stalls its input
        result_ch.ready <= 1'b0;
        hold_cycles <= 1500;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        hold_cycles <= pick_gap() - 1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed corners, then random phases under several register settings
  initial begin
    logic [TIME_W-1:0] phase_freq[8];
    logic [TIME_W-1:0] phase_limit[8];
    bit                phase_idle[8];

    mismatch_count = 0;
    idle_on = 1'b1;
    last_queued_ts = '0;
    freq_setting = FREQ_RESET;
    limit_setting = MAX_DELTA_RESET;
    prev_ts = '0;
    head = '0;
    window_total = '0;
    fill_count = '0;
    foreach (history[i]) history[i] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first frame, zero delta, truncation, clamp edge, saturation edge, wrap
    queue_timestamp(64'd0);
    queue_delta(64'd166_667);
    queue_delta(64'd0);
    queue_delta(64'd1);
    queue_delta(64'd1_000_000);
    queue_delta(64'd1_000_001);
    queue_delta(64'd999_999);
    queue_delta(64'd655_359_999);
    queue_delta(64'd655_360_000);
    queue_timestamp('1);
    queue_timestamp(64'd9);

    // Zero frequency saturates everything; clamp at zero
    reconfigure('0, '0);
    queue_delta(64'd0);
    queue_delta(64'd12_345);
    queue_timestamp({$urandom, $urandom});

    // One tick per second: smallest legal frequency, no clamp
    reconfigure(32'd1, '1);
    queue_delta(64'd0);
    queue_delta(64'd1);
    queue_delta(64'd65);
    queue_delta(64'd66);

    // Fastest counter, tightest nonzero clamp
    reconfigure('1, 32'd1);
    queue_delta(64'd1);
    queue_delta(64'd66);
    queue_delta(64'hFFFF_FFFF_FFFF_FFFF);

    phase_freq = '{32'd10_000_000, 32'd24_000_000, 32'd1_000_000_000, 32'd1,
                   32'hFFFF_FFFF, 32'd0, $urandom_range(1000, 32'hFFFF_FFFF), 32'd19_200_000};
    phase_limit = '{32'd1_092_267, 32'hFFFF_FFFF, 32'd3_276_800, 32'd0,
                    $urandom, $urandom, $urandom, 32'd2_000_000};
    phase_idle = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    for (int p = 0; p < 8; p++) begin
      reconfigure(phase_freq[p], phase_limit[p]);
      idle_on = phase_idle[p];
      for (int n = 0; n < 205; n++)
        queue_timestamp(random_timestamp(last_queued_ts, phase_freq[p]));
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && frame_stats_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up well past the slowest correct run
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
src/ftma_pkg.sv
src/ftma_if.sv
src/ftma_ring.sv
src/ftma_div.sv
src/frame_time_moving_average_unit.sv
src/ftma_checker.sv
tb/frame_time_moving_average_unit_test.sv
